/* rtl/core/sym3x3_matrix_inverse_unit_macros.svh */
// Assertion helpers for the RTL of the matrix inverse unit.
`ifndef SYM3X3_MATRIX_INVERSE_UNIT_MACROS_SVH
`define SYM3X3_MATRIX_INVERSE_UNIT_MACROS_SVH

// Same-cycle implication, sampled on clk, off while arst_n is low.
`define S3I_ASSERT_IMP(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, sampled on clk, off while arst_n is low.
`define S3I_ASSERT_NXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

/* rtl/core/s3inv_pkg.sv */
`default_nettype none

package s3inv_pkg;

	// Fixed data format of the matrix and inverse components.
	localparam int DATA_WIDTH    = 32;
	localparam int FRAC_BITS_DEF = 24;
	localparam int LANES         = 6;
	localparam int NPROD         = 2 * LANES;

	// Exact widths of the intermediate values.
	localparam int PROD_W = 2 * DATA_WIDTH;
	localparam int ADJ_W  = PROD_W + 1;
	localparam int TERM_W = DATA_WIDTH + ADJ_W;
	localparam int DET_W  = TERM_W + 2;
	// Quotient bits: DATA_WIDTH + 1 for the doubled quotient, one more for overflow.
	localparam int QB     = DATA_WIDTH + 2;

	// Indexes of the six input components and of the six output lanes.
	localparam int M_A = 0;
	localparam int M_B = 1;
	localparam int M_C = 2;
	localparam int M_D = 3;
	localparam int M_E = 4;
	localparam int M_F = 5;

	localparam int LN_XX = 0;
	localparam int LN_XY = 1;
	localparam int LN_XZ = 2;
	localparam int LN_YY = 3;
	localparam int LN_YZ = 4;
	localparam int LN_ZZ = 5;

	// Operand pairs of the twelve minor products; lane i is p[2i] - p[2i+1].
	localparam int PX [NPROD] = '{M_D, M_E, M_C, M_B, M_B, M_C, M_A, M_C, M_B, M_A, M_A, M_B};
	localparam int PY [NPROD] = '{M_F, M_E, M_E, M_F, M_E, M_D, M_F, M_C, M_C, M_E, M_D, M_B};

	typedef logic signed [DATA_WIDTH-1:0] data_t;
	typedef logic signed [PROD_W-1:0]     prod_t;
	typedef logic signed [ADJ_W-1:0]      adj_t;
	typedef logic signed [DATA_WIDTH:0]   part_t;
	typedef logic signed [TERM_W-1:0]     term_t;
	typedef logic signed [DET_W-1:0]      det_t;
	typedef logic        [DET_W-1:0]      dmag_t;
	typedef logic        [QB-1:0]         quo_t;

endpackage

`default_nettype wire

/* rtl/core/sym3x3_matrix_inverse_unit.sv */
// A transaction passes the front stages, the divider entry, the divide stages and the output register.
// Throughput: one transaction per cycle; the whole pipeline advances together
// and holds when the output register is full and not taken.
// The divide is restoring, one quotient bit per stage, six lanes side by side.
// Reset (arst_n low) clears every stage valid bit at once; data needs no reset.
`default_nettype none
`include "sym3x3_matrix_inverse_unit_macros.svh"

module sym3x3_matrix_inverse_unit
	import s3inv_pkg::*;
#(
	parameter int FRAC_BITS = FRAC_BITS_DEF
) (
	input  logic  clk,
	input  logic  arst_n,
	input  logic  in_valid,
	output logic  in_ready,
	input  data_t m_xx,
	input  data_t m_xy,
	input  data_t m_xz,
	input  data_t m_yy,
	input  data_t m_yz,
	input  data_t m_zz,
	output logic  out_valid,
	input  logic  out_ready,
	output data_t inv_xx,
	output data_t inv_xy,
	output data_t inv_xz,
	output data_t inv_yy,
	output data_t inv_yz,
	output data_t inv_zz,
	output logic  singular,
	output logic  saturated
);

	// Numerator is |adjugate| scaled by 2^(2F+1); the extra bit feeds rounding.
	localparam int NUM_W = ADJ_W + 2 * FRAC_BITS + 1;
	localparam int CMP_W = (NUM_W > DET_W + QB) ? NUM_W : DET_W + QB;
	localparam int NSTG  = QB;

	logic adv;
	logic vout_q;

	// Pipeline valid bits.
	logic v_s1, v_s2, v_s3, v_s4, v_s5, v_s6;
	logic div_v_sd [NSTG+1];

	// Data stages.
	data_t m_s1    [LANES];
	prod_t p_s2    [NPROD];
	data_t abc_s2  [3];
	adj_t  adj_s3  [LANES];
	data_t abc_s3  [3];
	adj_t  adj_s4  [LANES];
	prod_t plo_s4  [3];
	prod_t phi_s4  [3];
	adj_t  adj_s5  [LANES];
	term_t term_s5 [3];
	adj_t  adj_s6  [LANES];
	det_t  det_s6;

	// Divider stages; index 0 is the entry register.
	logic [NUM_W-1:0] div_rem_sd [NSTG+1][LANES];
	quo_t             div_q_sd   [NSTG+1][LANES];
	logic             div_neg_sd [NSTG+1][LANES];
	dmag_t            div_dm_sd  [NSTG+1];
	logic             div_sing_sd[NSTG+1];

	// Output register.
	data_t inv_q [LANES];
	logic  sing_q, sat_q;

	// The whole pipeline moves unless a result waits in the output register.
	assign adv      = !vout_q || out_ready;
	assign in_ready = adv;

	// Valid bits travel with their transaction.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1   <= 1'b0;
			v_s2   <= 1'b0;
			v_s3   <= 1'b0;
			v_s4   <= 1'b0;
			v_s5   <= 1'b0;
			v_s6   <= 1'b0;
			vout_q <= 1'b0;
			for (int k = 0; k <= NSTG; k++) div_v_sd[k] <= 1'b0;
		end else if (adv) begin
			v_s1        <= in_valid;
			v_s2        <= v_s1;
			v_s3        <= v_s2;
			v_s4        <= v_s3;
			v_s5        <= v_s4;
			v_s6        <= v_s5;
			div_v_sd[0] <= v_s6;
			for (int k = 0; k < NSTG; k++) div_v_sd[k+1] <= div_v_sd[k];
			vout_q      <= div_v_sd[NSTG];
		end
	end

	// Front stages: capture, minor products, minors, determinant partials, terms, sum.
	always_ff @(posedge clk) begin
		if (adv) begin
			m_s1[M_A] <= m_xx;
			m_s1[M_B] <= m_xy;
			m_s1[M_C] <= m_xz;
			m_s1[M_D] <= m_yy;
			m_s1[M_E] <= m_yz;
			m_s1[M_F] <= m_zz;

			for (int i = 0; i < NPROD; i++) p_s2[i] <= m_s1[PX[i]] * m_s1[PY[i]];
			for (int i = 0; i < 3; i++) abc_s2[i] <= m_s1[i];

			for (int i = 0; i < LANES; i++)
				adj_s3[i] <= ADJ_W'(p_s2[2*i]) - ADJ_W'(p_s2[2*i+1]);
			abc_s3 <= abc_s2;

			// Cofactor expansion along the first row, split at DATA_WIDTH bits.
			for (int i = 0; i < 3; i++) begin
				plo_s4[i] <= PROD_W'(abc_s3[i])
					* PROD_W'(part_t'({1'b0, adj_s3[i][DATA_WIDTH-1:0]}));
				phi_s4[i] <= PROD_W'(abc_s3[i])
					* PROD_W'(part_t'(adj_s3[i][ADJ_W-1:DATA_WIDTH]));
			end
			adj_s4 <= adj_s3;

			for (int i = 0; i < 3; i++)
				term_s5[i] <= (TERM_W'(phi_s4[i]) <<< DATA_WIDTH) + TERM_W'(plo_s4[i]);
			adj_s5 <= adj_s4;

			det_s6 <= DET_W'(term_s5[0]) + DET_W'(term_s5[1]) + DET_W'(term_s5[2]);
			adj_s6 <= adj_s5;
		end
	end

	// Divider: entry takes magnitudes, then one restoring step per stage.
	always_ff @(posedge clk) begin
		logic [CMP_W-1:0] sh;
		logic             ge;
		logic [ADJ_W-1:0] amag;
		if (adv) begin
			div_dm_sd[0]   <= det_s6[DET_W-1] ? dmag_t'(-det_s6) : dmag_t'(det_s6);
			div_sing_sd[0] <= (det_s6 == '0);
			for (int l = 0; l < LANES; l++) begin
				amag = adj_s6[l][ADJ_W-1] ? ADJ_W'(-adj_s6[l]) : ADJ_W'(adj_s6[l]);
				div_rem_sd[0][l] <= NUM_W'(amag) << (2 * FRAC_BITS + 1);
				div_q_sd[0][l]   <= '0;
				div_neg_sd[0][l] <= adj_s6[l][ADJ_W-1] ^ det_s6[DET_W-1];
			end
			for (int k = 0; k < NSTG; k++) begin
				div_dm_sd[k+1]   <= div_dm_sd[k];
				div_sing_sd[k+1] <= div_sing_sd[k];
				for (int l = 0; l < LANES; l++) begin
					sh = CMP_W'(div_dm_sd[k]) << (NSTG - 1 - k);
					ge = (CMP_W'(div_rem_sd[k][l]) >= sh);
					div_rem_sd[k+1][l] <= ge ? div_rem_sd[k][l] - sh[NUM_W-1:0]
						: div_rem_sd[k][l];
					div_q_sd[k+1][l]   <= div_q_sd[k][l] | (QB'(ge) << (NSTG - 1 - k));
					div_neg_sd[k+1][l] <= div_neg_sd[k][l];
				end
			end
		end
	end

	// Rounding (half away from zero), clamping and sign.
	data_t            res   [LANES];
	logic             lsat  [LANES];
	logic [DATA_WIDTH:0] qr [LANES];
	logic             any_sat;

	always_comb begin
		any_sat = 1'b0;
		for (int l = 0; l < LANES; l++) begin
			qr[l] = (DATA_WIDTH+1)'(({1'b0, div_q_sd[NSTG][l][QB-2:0]}
				+ (DATA_WIDTH+2)'(1)) >> 1);
			if (div_neg_sd[NSTG][l])
				lsat[l] = div_q_sd[NSTG][l][QB-1]
					|| (qr[l] > ((DATA_WIDTH+1)'(1) << (DATA_WIDTH - 1)));
			else
				lsat[l] = div_q_sd[NSTG][l][QB-1]
					|| (qr[l] >= ((DATA_WIDTH+1)'(1) << (DATA_WIDTH - 1)));
			if (lsat[l])
				res[l] = div_neg_sd[NSTG][l] ? data_t'({1'b1, {(DATA_WIDTH-1){1'b0}}})
					: data_t'({1'b0, {(DATA_WIDTH-1){1'b1}}});
			else
				res[l] = div_neg_sd[NSTG][l] ? data_t'(-qr[l][DATA_WIDTH-1:0])
					: data_t'(qr[l][DATA_WIDTH-1:0]);
			any_sat = any_sat | lsat[l];
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			for (int l = 0; l < LANES; l++)
				inv_q[l] <= div_sing_sd[NSTG] ? '0 : res[l];
			sing_q <= div_sing_sd[NSTG];
			sat_q  <= !div_sing_sd[NSTG] && any_sat;
		end
	end

	assign out_valid = vout_q;
	assign inv_xx    = inv_q[LN_XX];
	assign inv_xy    = inv_q[LN_XY];
	assign inv_xz    = inv_q[LN_XZ];
	assign inv_yy    = inv_q[LN_YY];
	assign inv_yz    = inv_q[LN_YZ];
	assign inv_zz    = inv_q[LN_ZZ];
	assign singular  = sing_q;
	assign saturated = sat_q;

	// A singular result carries zero components and no clamp flag.
	`S3I_ASSERT_IMP(a_sing_zero, out_valid && singular, inv_xx == '0 && inv_xy == '0 && inv_xz == '0 && inv_yy == '0 && inv_yz == '0 && inv_zz == '0 && !saturated, "singular result has nonzero data")
	// The divider entry follows the last front stage when the pipeline moves.
	`S3I_ASSERT_NXT(a_div_entry, adv && v_s6, div_v_sd[0], "transaction lost at divider entry")
	// A held result is never replaced by the next one.
	`S3I_ASSERT_NXT(a_hold, out_valid && !out_ready, out_valid && $stable(inv_xx) && $stable(singular), "stalled result not held")

endmodule

`default_nettype wire
